// File: sv/s256r_pkg.sv
package s256r_pkg;

   // Request codes carried in the req_type field
   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_FORWARD = 2'd1,
      REQ_INVERSE = 2'd2
   } s256r_op_type;

   // Round indices at or above this count are ignored
   localparam logic [6:0] NUM_ROUNDS = 7'd64;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  word_index;
      logic [31:0] load_value;
      logic [31:0] message_word;
      logic [5:0]  round_index;
   } s256r_req_type;

   typedef struct packed {
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] word_d;
      logic [31:0] word_e;
      logic [31:0] word_f;
      logic [31:0] word_g;
      logic [31:0] word_h;
   } s256r_rsp_type;

   // Round constants
   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] v);
      return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] v);
      return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
      return (x & y) ^ (~x & z);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z);
      return (x & y) ^ (x & z) ^ (y & z);
   endfunction

endpackage

// File: sv/sha256_round_forward_inverse_unit.sv
// Path: request register, then response register, with the round computed between
// them.
// Throughput: one request per cycle while the receiver does not stall; the next item sees the state left by the last.
// Reset (synchronous): empties both stages and clears the working words A..H to zero.
module sha256_round_forward_inverse_unit
   import s256r_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  s256r_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output s256r_rsp_type rsp_data
);

   logic          req_vld_ff, req_vld_in;
   s256r_req_type req_ff, req_in;
   logic          rsp_vld_ff, rsp_vld_in;
   s256r_rsp_type rsp_ff, rsp_in;
   logic [31:0]   state_ff [8];
   logic [31:0]   state_in [8];

   logic          advance;
   logic          in_range;
   logic [31:0]   k_word;
   logic [31:0]   fwd_t1, fwd_t2;
   logic [31:0]   inv_t1, inv_t2, inv_part;

   // Move the held beat on when the response register is free or being taken
   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign req_stall = req_vld_ff && !advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Round terms
   assign in_range = {1'b0, req_ff.round_index} < NUM_ROUNDS;
   assign k_word   = ROUND_K[req_ff.round_index];
   assign fwd_t1   = state_ff[7] + big_sigma1(state_ff[4])
                     + choose(state_ff[4], state_ff[5], state_ff[6])
                     + k_word + req_ff.message_word;
   assign fwd_t2   = big_sigma0(state_ff[0]) + majority(state_ff[0], state_ff[1], state_ff[2]);
   assign inv_t2   = big_sigma0(state_ff[1]) + majority(state_ff[1], state_ff[2], state_ff[3]);
   assign inv_t1   = state_ff[0] - inv_t2;
   assign inv_part = big_sigma1(state_ff[5]) + choose(state_ff[5], state_ff[6], state_ff[7])
                     + k_word + req_ff.message_word;

   // Next working state
   always_comb begin
      state_in = state_ff;
      if (req_vld_ff && advance) begin
         case (req_ff.req_type)
            REQ_LOAD: begin
               state_in[req_ff.word_index] = req_ff.load_value;
            end
            REQ_FORWARD: begin
               if (in_range) begin
                  state_in[7] = state_ff[6];
                  state_in[6] = state_ff[5];
                  state_in[5] = state_ff[4];
                  state_in[4] = state_ff[3] + fwd_t1;
                  state_in[3] = state_ff[2];
                  state_in[2] = state_ff[1];
                  state_in[1] = state_ff[0];
                  state_in[0] = fwd_t1 + fwd_t2;
               end
            end
            REQ_INVERSE: begin
               if (in_range) begin
                  state_in[0] = state_ff[1];
                  state_in[1] = state_ff[2];
                  state_in[2] = state_ff[3];
                  state_in[3] = state_ff[4] - inv_t1;
                  state_in[4] = state_ff[5];
                  state_in[5] = state_ff[6];
                  state_in[6] = state_ff[7];
                  state_in[7] = inv_t1 - inv_part;
               end
            end
            default: begin
               // unused code: hold the state
            end
         endcase
      end
   end

   // Stage control and payload
   always_comb begin
      req_vld_in = req_vld_ff;
      req_in     = req_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (!req_stall) begin
         req_vld_in = req_valid;
         if (req_valid) begin
            req_in = req_data;
         end
      end
      if (advance) begin
         rsp_vld_in = req_vld_ff;
         if (req_vld_ff) begin
            rsp_in = '{word_a: state_in[0], word_b: state_in[1], word_c: state_in[2],
                       word_d: state_in[3], word_e: state_in[4], word_f: state_in[5],
                       word_g: state_in[6], word_h: state_in[7]};
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            state_ff[i] <= '0;
         end
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
      end
   end

endmodule

// File: sim/tb.sv
module tb;
   import s256r_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Request code with no operation behind it
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam logic [31:0] ROUND_CONSTANTS [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam int DIRECTED_ITEMS = 17;
   localparam int RANDOM_ITEMS   = 1600;

   // Tracks the working words A..H and the states still owed by the block
   class state_scoreboard;
      logic [31:0]   words [8];
      s256r_rsp_type expected_states [$];
      int            failures;

      function new();
         foreach (words[i]) words[i] = '0;
         failures = 0;
      endfunction

      static function logic [31:0] rot_right(logic [31:0] v, int s);
         return (v >> s) | (v << (32 - s));
      endfunction

      static function logic [31:0] csigma0(logic [31:0] v);
         return rot_right(v, 2) ^ rot_right(v, 13) ^ rot_right(v, 22);
      endfunction

      static function logic [31:0] csigma1(logic [31:0] v);
         return rot_right(v, 6) ^ rot_right(v, 11) ^ rot_right(v, 25);
      endfunction

      static function logic [31:0] ch_bits(logic [31:0] x, logic [31:0] y, logic [31:0] z);
         return (x & y) ^ (~x & z);
      endfunction

      static function logic [31:0] maj_bits(logic [31:0] x, logic [31:0] y, logic [31:0] z);
         return (x & y) ^ (x & z) ^ (y & z);
      endfunction

      function void round_forward(logic [31:0] w, logic [31:0] k);
         logic [31:0] t1;
         logic [31:0] t2;
         t1 = words[7] + csigma1(words[4]) + ch_bits(words[4], words[5], words[6]) + k + w;
         t2 = csigma0(words[0]) + maj_bits(words[0], words[1], words[2]);
         for (int i = 7; i > 0; i--) words[i] = words[i-1];
         words[4] = words[4] + t1;
         words[0] = t1 + t2;
      endfunction

      // Recover the earlier D and H by subtraction, shift the rest back
      function void round_inverse(logic [31:0] w, logic [31:0] k);
         logic [31:0] t1;
         logic [31:0] t2;
         logic [31:0] part;
         logic [31:0] old_d;
         logic [31:0] old_h;
         t2    = csigma0(words[1]) + maj_bits(words[1], words[2], words[3]);
         t1    = words[0] - t2;
         part  = csigma1(words[5]) + ch_bits(words[5], words[6], words[7]) + k + w;
         old_h = t1 - part;
         old_d = words[4] - t1;
         for (int i = 0; i < 7; i++) words[i] = words[i+1];
         words[3] = old_d;
         words[7] = old_h;
      endfunction

      // Apply one accepted request beat and queue the state it leaves
      function void note_request(s256r_req_type r);
         s256r_rsp_type next_state;
         logic          in_range;
         in_range = {1'b0, r.round_index} < NUM_ROUNDS;
         if (r.req_type == REQ_LOAD) begin
            words[r.word_index] = r.load_value;
         end else if (r.req_type == REQ_FORWARD && in_range) begin
            round_forward(r.message_word, ROUND_CONSTANTS[r.round_index]);
         end else if (r.req_type == REQ_INVERSE && in_range) begin
            round_inverse(r.message_word, ROUND_CONSTANTS[r.round_index]);
         end
         next_state = {words[0], words[1], words[2], words[3],
                       words[4], words[5], words[6], words[7]};
         expected_states = {expected_states, next_state};
      endfunction

      function void check_response(s256r_rsp_type got);
         s256r_rsp_type want;
         logic [31:0]   got_words [8];
         logic [31:0]   want_words [8];
         string         names [8];
         names = '{"word_a", "word_b", "word_c", "word_d",
                   "word_e", "word_f", "word_g", "word_h"};
         if (expected_states.size() == 0) begin
            failures++;
            if (failures <= 10) $display("response beat with nothing pending: %h", got);
            return;
         end
         want = expected_states.pop_front();
         got_words  = '{got.word_a, got.word_b, got.word_c, got.word_d,
                        got.word_e, got.word_f, got.word_g, got.word_h};
         want_words = '{want.word_a, want.word_b, want.word_c, want.word_d,
                        want.word_e, want.word_f, want.word_g, want.word_h};
         for (int i = 0; i < 8; i++) begin
            if (got_words[i] !== want_words[i]) begin
               failures++;
               if (failures <= 10)
                  $display("%s mismatch: expected %h, got %h",
                           names[i], want_words[i], got_words[i]);
            end
         end
      endfunction

      function int pending();
         return expected_states.size();
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   s256r_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   s256r_rsp_type rsp_data;

   state_scoreboard tracker;
   int              burst_left;
   int              accepted;

   sha256_round_forward_inverse_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the block hangs
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic s256r_req_type make_request(logic [1:0] op, logic [2:0] idx,
                                                  logic [31:0] val, logic [31:0] w,
                                                  logic [5:0] t);
      s256r_req_type r;
      r.req_type     = op;
      r.word_index   = idx;
      r.load_value   = val;
      r.message_word = w;
      r.round_index  = t;
      return r;
   endfunction

   function automatic s256r_req_type random_request(logic [1:0] op);
      return make_request(op, 3'($urandom_range(0, 7)), $urandom, $urandom,
                          6'($urandom_range(0, 63)));
   endfunction

   // Hold a beat until accepted; open a random gap, possibly empty, between bursts
   task automatic send_request(input s256r_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_data  <= random_request(2'($urandom_range(0, 3)));
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
      accepted++;
   endtask

   // Run forward rounds, then undo them in reverse order
   task automatic forward_then_undo(input int n);
      logic [31:0] w_list [8];
      logic [5:0]  t_list [8];
      logic [5:0]  t0;
      t0 = 6'($urandom_range(0, 63));
      for (int i = 0; i < n; i++) begin
         w_list[i] = $urandom;
         t_list[i] = ($urandom_range(0, 1) == 0) ? 6'(t0 + i) : 6'($urandom_range(0, 63));
         send_request(make_request(REQ_FORWARD, 3'($urandom_range(0, 7)), $urandom,
                                   w_list[i], t_list[i]));
      end
      for (int i = n - 1; i >= 0; i--)
         send_request(make_request(REQ_INVERSE, 3'($urandom_range(0, 7)), $urandom,
                                   w_list[i], t_list[i]));
   endtask

   // Receiver: stall on its own changing pattern
   initial begin
      int mode;
      int span;
      int tick;
      mode = 0;
      span = 0;
      tick = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 200);
         end
         span--;
         tick++;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (tick % 5) < 2;
         endcase
      end
   end

   // Check each accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(rsp_data);
   end

   initial begin
      int pick;
      int waited;
      tracker    = new();
      burst_left = 0;
      accepted   = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of every word, both rounds at the ends of the table
      for (int i = 0; i < 8; i++)
         send_request(make_request(REQ_LOAD, 3'(i), 32'hffffffff, $urandom, 6'($urandom)));
      send_request(make_request(REQ_FORWARD, 3'd7, 32'hffffffff, 32'h0, 6'd0));
      send_request(make_request(REQ_FORWARD, 3'd0, 32'h0, 32'hffffffff, 6'd63));
      send_request(make_request(REQ_INVERSE, 3'd5, $urandom, 32'hffffffff, 6'd63));
      send_request(make_request(REQ_INVERSE, 3'd2, $urandom, 32'h0, 6'd0));
      send_request(make_request(REQ_SPARE, 3'd7, 32'hffffffff, 32'hffffffff, 6'd63));
      send_request(make_request(REQ_LOAD, 3'd0, 32'h0, 32'hffffffff, 6'd63));
      send_request(make_request(REQ_LOAD, 3'd7, 32'h0, 32'h0, 6'd0));
      send_request(make_request(REQ_FORWARD, 3'd3, $urandom, 32'h12345678, 6'd31));
      send_request(make_request(REQ_INVERSE, 3'd4, $urandom, 32'h9abcdef0, 6'd31));

      // Random: mostly undoable round chains and loads, some noise
      while (accepted < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            forward_then_undo($urandom_range(1, 8));
         end else if (pick < 60) begin
            repeat ($urandom_range(1, 8)) send_request(random_request(REQ_LOAD));
         end else if (pick < 70) begin
            send_request(random_request(REQ_SPARE));
         end else begin
            repeat ($urandom_range(1, 12))
               send_request(random_request(($urandom_range(0, 1) == 0) ? REQ_FORWARD
                                                                        : REQ_INVERSE));
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow for the pipeline depth
      waited = 0;
      while (tracker.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
